FILE: rtl/rsbb_pkg.sv
package rsbb_pkg;

	localparam int unsigned TRIG_TABLE_BITS_DEF = 10;

	// Field widths
	localparam int unsigned POS_W      = 24;
	localparam int unsigned SCALE_W    = 13;
	localparam int unsigned ANGLE_W    = 16;
	localparam int unsigned DIM_W      = 12;
	localparam int unsigned ORIGIN_W   = 9;
	localparam int unsigned BOX_W      = 16;

	// Configuration port
	localparam int unsigned CFG_INDEX_W = 4;
	localparam int unsigned CFG_DATA_W  = 12;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_X     = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ORIGIN_Y     = 4'd3;

	// Sine/cosine: magnitude 0..16384 (Q1.14), signed value one bit wider
	localparam int unsigned TRIG_MAG_W = 15;
	localparam int unsigned TRIG_W     = 16;

	// Corner sums are Q30 pixels
	localparam int unsigned SUM_W     = 54;
	localparam int unsigned FRAC_BITS = 30;

	// One full turn in Q9.6 degrees
	localparam int unsigned TURN_Q6 = 23040;

	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
		logic s7;
	} stage_en_t;

	localparam longint unsigned ONE_Q30 = 64'd1 << 30;
	localparam longint unsigned PI_Q40  = 64'hC90FDAA22168C234 >> 22;
	localparam longint unsigned SIN_DEN [8] = '{272, 210, 156, 110, 72, 42, 20, 6};
	localparam longint unsigned COS_DEN [8] = '{240, 182, 132, 90, 56, 30, 12, 2};

	// First-quadrant sine or cosine of step r out of 2^bits per turn, Q1.14 magnitude.
	// Taylor series in Q30, evaluated Horner style from the highest term.
	function automatic logic [TRIG_MAG_W-1:0] trig_mag(input longint unsigned r,
			input int unsigned bits, input bit cosine);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned ts;
		longint unsigned tc;
		longint unsigned v;
		longint unsigned res;
		x = (r * PI_Q40 + (64'd1 << (bits + 8))) >> (bits + 9);
		x2 = (x * x) >> 30;
		ts = ONE_Q30;
		tc = ONE_Q30;
		for (int i = 0; i < 8; i++) begin
			v = ((x2 * ts) >> 30) / SIN_DEN[i];
			ts = (v >= ONE_Q30) ? 64'd0 : ONE_Q30 - v;
			v = ((x2 * tc) >> 30) / COS_DEN[i];
			tc = (v >= ONE_Q30) ? 64'd0 : ONE_Q30 - v;
		end
		if (cosine)
			res = (tc + (64'd1 << 15)) >> 16;
		else
			res = (((x * ts) >> 30) + (64'd1 << 15)) >> 16;
		return res[TRIG_MAG_W-1:0];
	endfunction

endpackage

FILE: rtl/rotated_sprite_bounding_box.sv
// Axis-aligned bounding box of a scaled, rotated sprite frame. Each transfer on the
// input carries a Q16.8 position, a Q4.8 scale per axis (magnitude used) and a Q9.6
// angle in degrees; the frame, sized by frame_width/frame_height and placed around the
// position by the Q1.8 pivot origin_x/origin_y, is rotated by the negated angle about
// the position, and the box edges come out in whole pixels, truncated toward zero and
// clamped to 16 bits. The block takes one item per clock unless a stalled output has
// filled every stage, and passes it through the pipeline stages scale, pivot multiply,
// sine/cosine table read, rotation multiply, corner sums, truncation and min/max. The
// sine/cosine table holds a quarter wave of 2^TRIG_TABLE_BITS steps per turn. Write
// the configuration registers only while no item is in flight.
module rotated_sprite_bounding_box #(
	parameter int unsigned TRIG_TABLE_BITS = rsbb_pkg::TRIG_TABLE_BITS_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_write,
	input  logic [rsbb_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [rsbb_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [rsbb_pkg::POS_W-1:0]       pos_x,
	input  logic signed [rsbb_pkg::POS_W-1:0]       pos_y,
	input  logic signed [rsbb_pkg::SCALE_W-1:0]     scale_x,
	input  logic signed [rsbb_pkg::SCALE_W-1:0]     scale_y,
	input  logic signed [rsbb_pkg::ANGLE_W-1:0]     angle,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [rsbb_pkg::BOX_W-1:0]       box_left,
	output logic signed [rsbb_pkg::BOX_W-1:0]       box_top,
	output logic signed [rsbb_pkg::BOX_W-1:0]       box_right,
	output logic signed [rsbb_pkg::BOX_W-1:0]       box_bottom
);
	import rsbb_pkg::*;

	localparam int unsigned STAGES    = 7;
	localparam int unsigned EXT_W     = DIM_W + SCALE_W;
	localparam int unsigned DX_W      = EXT_W + ORIGIN_W + 2;
	localparam int unsigned PROD_W    = DX_W + TRIG_W;
	localparam int unsigned SPAN_W    = ORIGIN_W + 1;
	localparam int unsigned PIVOT_ONE = 256;
	localparam int unsigned POS_SHIFT = 22;

	localparam logic [DIM_W-1:0]    FRAME_RST  = DIM_W'(32);
	localparam logic [ORIGIN_W-1:0] ORIGIN_RST = ORIGIN_W'(128);

	logic [DIM_W-1:0]    frame_width_q;
	logic [DIM_W-1:0]    frame_height_q;
	logic [ORIGIN_W-1:0] origin_x_q;
	logic [ORIGIN_W-1:0] origin_y_q;

	logic [STAGES:1] vld_q;
	logic [STAGES:1] rdy;
	stage_en_t       en;
	logic            in_fire;
	logic            out_fire;

	logic [SCALE_W-1:0] scale_x_mag;
	logic [SCALE_W-1:0] scale_y_mag;
	logic signed [SPAN_W-1:0] span_x;
	logic signed [SPAN_W-1:0] span_y;
	logic [DX_W-1:0] lo_x;
	logic [DX_W-1:0] lo_y;

	logic [EXT_W-1:0]          sw_s1;
	logic [EXT_W-1:0]          sh_s1;
	logic signed [POS_W-1:0]   px_s1, px_s2, px_s3, px_s4;
	logic signed [POS_W-1:0]   py_s1, py_s2, py_s3, py_s4;
	logic signed [DX_W-1:0]    dx_s2 [2];
	logic signed [DX_W-1:0]    dy_s2 [2];
	logic signed [DX_W-1:0]    dx_s3 [2];
	logic signed [DX_W-1:0]    dy_s3 [2];
	logic signed [TRIG_W-1:0]  sin_q14;
	logic signed [TRIG_W-1:0]  cos_q14;
	logic signed [PROD_W-1:0]  dxc_s4 [2];
	logic signed [PROD_W-1:0]  dxs_s4 [2];
	logic signed [PROD_W-1:0]  dyc_s4 [2];
	logic signed [PROD_W-1:0]  dys_s4 [2];
	logic signed [SUM_W-1:0]   rx_s5 [4];
	logic signed [SUM_W-1:0]   ry_s5 [4];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_RST;
			frame_height_q <= FRAME_RST;
			origin_x_q     <= ORIGIN_RST;
			origin_y_q     <= ORIGIN_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH:  frame_width_q  <= cfg_data[DIM_W-1:0];
				CFG_FRAME_HEIGHT: frame_height_q <= cfg_data[DIM_W-1:0];
				CFG_ORIGIN_X:     origin_x_q     <= cfg_data[ORIGIN_W-1:0];
				CFG_ORIGIN_Y:     origin_y_q     <= cfg_data[ORIGIN_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage advances when it is empty or the one after it advances,
	// so bubbles close up behind a stalled output.
	always_comb begin
		rdy[STAGES] = !vld_q[STAGES] || out_ready;
		for (int k = STAGES - 1; k >= 1; k--)
			rdy[k] = !vld_q[k] || rdy[k+1];
	end

	assign en = '{s1: rdy[1], s2: rdy[2], s3: rdy[3], s4: rdy[4],
		s5: rdy[5], s6: rdy[6], s7: rdy[7]};

	assign in_ready  = rdy[1];
	assign out_valid = vld_q[STAGES];
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1])
				vld_q[1] <= in_valid;
			for (int k = 2; k <= STAGES; k++)
				if (rdy[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	// Stage 1: scaled frame size
	assign scale_x_mag = scale_x[SCALE_W-1] ? $unsigned(-scale_x) : $unsigned(scale_x);
	assign scale_y_mag = scale_y[SCALE_W-1] ? $unsigned(-scale_y) : $unsigned(scale_y);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			sw_s1 <= EXT_W'(frame_width_q) * EXT_W'(scale_x_mag);
			sh_s1 <= EXT_W'(frame_height_q) * EXT_W'(scale_y_mag);
			px_s1 <= pos_x;
			py_s1 <= pos_y;
		end
	end

	// Stage 2: corner offsets from the pivot, Q16
	always_comb begin
		span_x = $signed(SPAN_W'(PIVOT_ONE) - SPAN_W'(origin_x_q));
		span_y = $signed(SPAN_W'(PIVOT_ONE) - SPAN_W'(origin_y_q));
		lo_x   = DX_W'(sw_s1) * DX_W'(origin_x_q);
		lo_y   = DX_W'(sh_s1) * DX_W'(origin_y_q);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			dx_s2[0] <= -$signed(lo_x);
			dx_s2[1] <= $signed(DX_W'(sw_s1)) * DX_W'(span_x);
			dy_s2[0] <= -$signed(lo_y);
			dy_s2[1] <= $signed(DX_W'(sh_s1)) * DX_W'(span_y);
			px_s2    <= px_s1;
			py_s2    <= py_s1;
		end
	end

	rsbb_phase #(
		.TRIG_TABLE_BITS(TRIG_TABLE_BITS)
	) u_phase (
		.clk     (clk),
		.en      (en),
		.angle   (angle),
		.sin_q14 (sin_q14),
		.cos_q14 (cos_q14)
	);

	// Stage 3: hold offsets while the table is read
	always_ff @(posedge clk) begin
		if (en.s3) begin
			dx_s3 <= dx_s2;
			dy_s3 <= dy_s2;
			px_s3 <= px_s2;
			py_s3 <= py_s2;
		end
	end

	// Stage 4: rotation products
	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int i = 0; i < 2; i++) begin
				dxc_s4[i] <= PROD_W'(dx_s3[i]) * PROD_W'(cos_q14);
				dxs_s4[i] <= PROD_W'(dx_s3[i]) * PROD_W'(sin_q14);
				dyc_s4[i] <= PROD_W'(dy_s3[i]) * PROD_W'(cos_q14);
				dys_s4[i] <= PROD_W'(dy_s3[i]) * PROD_W'(sin_q14);
			end
			px_s4 <= px_s3;
			py_s4 <= py_s3;
		end
	end

	// Stage 5: rotated corners in Q30
	always_ff @(posedge clk) begin
		if (en.s5) begin
			for (int i = 0; i < 2; i++) begin
				for (int j = 0; j < 2; j++) begin
					rx_s5[2*i+j] <= (SUM_W'(px_s4) <<< POS_SHIFT) + SUM_W'(dxc_s4[i])
						- SUM_W'(dys_s4[j]);
					ry_s5[2*i+j] <= (SUM_W'(py_s4) <<< POS_SHIFT) + SUM_W'(dxs_s4[i])
						+ SUM_W'(dyc_s4[j]);
				end
			end
		end
	end

	rsbb_reduce u_reduce (
		.clk        (clk),
		.en         (en),
		.rx         (rx_s5),
		.ry         (ry_s5),
		.box_left   (box_left),
		.box_top    (box_top),
		.box_right  (box_right),
		.box_bottom (box_bottom)
	);

	// Items in flight change only by transfers at the two ends
	assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones(vld_q) ==
			$past($countones(vld_q)) + int'($past(in_fire)) - int'($past(out_fire))))
		else $error("pipeline occupancy does not match transfers");

	// Input stalls only when every stage is full behind a stalled output
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (&vld_q) && !out_ready)
		else $error("input stalled with room in the pipeline");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (box_left <= box_right) && (box_bottom <= box_top))
		else $error("box edges out of order");

endmodule

FILE: rtl/rsbb_trig_rom.sv
module rsbb_trig_rom #(
	parameter int unsigned TRIG_TABLE_BITS = rsbb_pkg::TRIG_TABLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic [TRIG_TABLE_BITS-3:0]        addr,
	output logic [rsbb_pkg::TRIG_MAG_W-1:0]   sin_mag_s3,
	output logic [rsbb_pkg::TRIG_MAG_W-1:0]   cos_mag_s3
);
	import rsbb_pkg::*;

	localparam int unsigned DEPTH = 1 << (TRIG_TABLE_BITS - 2);

	logic [TRIG_MAG_W-1:0] sin_rom [DEPTH];
	logic [TRIG_MAG_W-1:0] cos_rom [DEPTH];

	for (genvar g = 0; g < DEPTH; g++) begin : g_rom
		assign sin_rom[g] = trig_mag(longint'(g), TRIG_TABLE_BITS, 1'b0);
		assign cos_rom[g] = trig_mag(longint'(g), TRIG_TABLE_BITS, 1'b1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sin_mag_s3 <= sin_rom[addr];
			cos_mag_s3 <= cos_rom[addr];
		end
	end

endmodule

FILE: rtl/rsbb_phase.sv
module rsbb_phase #(
	parameter int unsigned TRIG_TABLE_BITS = rsbb_pkg::TRIG_TABLE_BITS_DEF
) (
	input  logic                                clk,
	input  rsbb_pkg::stage_en_t                 en,
	input  logic signed [rsbb_pkg::ANGLE_W-1:0] angle,
	output logic signed [rsbb_pkg::TRIG_W-1:0]  sin_q14,
	output logic signed [rsbb_pkg::TRIG_W-1:0]  cos_q14
);
	import rsbb_pkg::*;

	localparam int unsigned B      = TRIG_TABLE_BITS;
	localparam int unsigned TW     = ANGLE_W + 2 + B;
	localparam int unsigned UW     = TW - 9;
	// Turn is 512 * 45: shift off the 512, then divide by 45 via reciprocal
	localparam int unsigned W      = B + 13;
	localparam int unsigned SH     = W + 6;
	localparam longint unsigned RECIP  = ((64'd1 << SH) + 64'd44) / 64'd45;
	localparam longint unsigned OFFSET = 64'd45 << (B + 7);
	localparam int unsigned PW     = 2 * W + 1;
	localparam int unsigned AW     = B - 2;
	localparam int unsigned HALF_STEP = TURN_Q6 / 2;

	logic signed [ANGLE_W:0]    neg_angle;
	logic signed [TW-1:0]       scaled;
	logic signed [UW-1:0]       coarse;
	logic [W-1:0]               biased;
	logic [W-1:0]               biased_s1;
	logic [PW-1:0]              quot;
	logic [B-1:0]               idx_s2;
	logic [1:0]                 quad_s3;
	logic [TRIG_MAG_W-1:0]      sin_mag_s3;
	logic [TRIG_MAG_W-1:0]      cos_mag_s3;
	logic signed [TRIG_W-1:0]   s0;
	logic signed [TRIG_W-1:0]   c0;

	// Round(-angle * 2^B / turn), half up; the bias keeps the quotient positive
	// and is a whole number of turns (a multiple of 2^B steps), so the index modulo 2^B is unaffected.
	always_comb begin
		neg_angle = -(ANGLE_W + 1)'(angle);
		scaled    = (TW'(neg_angle) <<< B) + TW'(HALF_STEP);
		coarse    = scaled[TW-1:9];
		biased    = W'(coarse) + W'(OFFSET);
	end

	always_ff @(posedge clk) begin
		if (en.s1)
			biased_s1 <= biased;
	end

	assign quot = PW'(biased_s1) * PW'(RECIP);

	always_ff @(posedge clk) begin
		if (en.s2)
			idx_s2 <= quot[SH+B-1:SH];
	end

	rsbb_trig_rom #(
		.TRIG_TABLE_BITS(TRIG_TABLE_BITS)
	) u_rom (
		.clk        (clk),
		.en         (en.s3),
		.addr       (idx_s2[AW-1:0]),
		.sin_mag_s3 (sin_mag_s3),
		.cos_mag_s3 (cos_mag_s3)
	);

	always_ff @(posedge clk) begin
		if (en.s3)
			quad_s3 <= idx_s2[B-1:B-2];
	end

	// Fold the quarter-wave values out to the full turn
	always_comb begin
		s0 = $signed(TRIG_W'(sin_mag_s3));
		c0 = $signed(TRIG_W'(cos_mag_s3));
		case (quad_s3)
			2'd0: begin
				sin_q14 = s0;
				cos_q14 = c0;
			end
			2'd1: begin
				sin_q14 = c0;
				cos_q14 = -s0;
			end
			2'd2: begin
				sin_q14 = -s0;
				cos_q14 = -c0;
			end
			default: begin
				sin_q14 = -c0;
				cos_q14 = s0;
			end
		endcase
	end

endmodule

FILE: rtl/rsbb_reduce.sv
module rsbb_reduce (
	input  logic                               clk,
	input  rsbb_pkg::stage_en_t                en,
	input  logic signed [rsbb_pkg::SUM_W-1:0]  rx [4],
	input  logic signed [rsbb_pkg::SUM_W-1:0]  ry [4],
	output logic signed [rsbb_pkg::BOX_W-1:0]  box_left,
	output logic signed [rsbb_pkg::BOX_W-1:0]  box_top,
	output logic signed [rsbb_pkg::BOX_W-1:0]  box_right,
	output logic signed [rsbb_pkg::BOX_W-1:0]  box_bottom
);
	import rsbb_pkg::*;

	localparam int unsigned WHOLE_W = SUM_W - FRAC_BITS;
	localparam longint unsigned TRUNC_BIAS = (64'd1 << FRAC_BITS) - 64'd1;
	localparam int BOX_MAX = 32767;
	localparam int BOX_MIN = -32768;

	// Drop the fraction toward zero, then clamp to the box range
	function automatic logic signed [BOX_W-1:0] trunc_sat(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0]   adj;
		logic signed [WHOLE_W-1:0] whole;
		adj = v + (v[SUM_W-1] ? SUM_W'(TRUNC_BIAS) : SUM_W'(0));
		whole = adj[SUM_W-1:FRAC_BITS];
		if (whole > WHOLE_W'(BOX_MAX))
			return BOX_W'(BOX_MAX);
		else if (whole < WHOLE_W'(BOX_MIN))
			return BOX_W'(BOX_MIN);
		else
			return whole[BOX_W-1:0];
	endfunction

	logic signed [BOX_W-1:0] x_int_s6 [4];
	logic signed [BOX_W-1:0] y_int_s6 [4];
	logic signed [BOX_W-1:0] x_min;
	logic signed [BOX_W-1:0] x_max;
	logic signed [BOX_W-1:0] y_min;
	logic signed [BOX_W-1:0] y_max;

	always_ff @(posedge clk) begin
		if (en.s6) begin
			for (int i = 0; i < 4; i++) begin
				x_int_s6[i] <= trunc_sat(rx[i]);
				y_int_s6[i] <= trunc_sat(ry[i]);
			end
		end
	end

	always_comb begin
		x_min = x_int_s6[0];
		x_max = x_int_s6[0];
		y_min = y_int_s6[0];
		y_max = y_int_s6[0];
		for (int i = 1; i < 4; i++) begin
			if (x_int_s6[i] < x_min) x_min = x_int_s6[i];
			if (x_int_s6[i] > x_max) x_max = x_int_s6[i];
			if (y_int_s6[i] < y_min) y_min = y_int_s6[i];
			if (y_int_s6[i] > y_max) y_max = y_int_s6[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s7) begin
			box_left   <= x_min;
			box_right  <= x_max;
			box_top    <= y_max;
			box_bottom <= y_min;
		end
	end

endmodule

FILE: tb/tb_rotated_sprite_bounding_box.sv
module tb_rotated_sprite_bounding_box;
	timeunit 1ns;
	timeprecision 1ps;

	import rsbb_pkg::*;

	localparam int unsigned TBITS = TRIG_TABLE_BITS_DEF;
	localparam int PIPE_DEPTH = 7;
	localparam longint TURN = 23040;
	localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
	localparam longint unsigned PI_FIX = 64'hC90FDAA22168C234 >> 22;
	localparam longint unsigned SIN_DIV [8] = '{272, 210, 156, 110, 72, 42, 20, 6};
	localparam longint unsigned COS_DIV [8] = '{240, 182, 132, 90, 56, 30, 12, 2};
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 235;

	typedef struct packed {
		logic signed [POS_W-1:0]   px;
		logic signed [POS_W-1:0]   py;
		logic signed [SCALE_W-1:0] sx;
		logic signed [SCALE_W-1:0] sy;
		logic signed [ANGLE_W-1:0] ang;
	} sprite_t;

	typedef struct packed {
		logic signed [BOX_W-1:0] left;
		logic signed [BOX_W-1:0] top;
		logic signed [BOX_W-1:0] right;
		logic signed [BOX_W-1:0] bottom;
	} box_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [POS_W-1:0] pos_x = '0;
	logic signed [POS_W-1:0] pos_y = '0;
	logic signed [SCALE_W-1:0] scale_x = '0;
	logic signed [SCALE_W-1:0] scale_y = '0;
	logic signed [ANGLE_W-1:0] angle = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [BOX_W-1:0] box_left;
	logic signed [BOX_W-1:0] box_top;
	logic signed [BOX_W-1:0] box_right;
	logic signed [BOX_W-1:0] box_bottom;

	// shadow copy of the configuration registers
	logic [DIM_W-1:0] frame_w_q = 12'd32;
	logic [DIM_W-1:0] frame_h_q = 12'd32;
	logic [ORIGIN_W-1:0] origin_x_q = 9'd128;
	logic [ORIGIN_W-1:0] origin_y_q = 9'd128;

	sprite_t sprites_pending[$];
	box_t boxes_due[$];
	int boxes_owed = 0;
	int boxes_checked = 0;
	int mismatches = 0;

	rotated_sprite_bounding_box dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.scale_x(scale_x),
		.scale_y(scale_y),
		.angle(angle),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.box_left(box_left),
		.box_top(box_top),
		.box_right(box_right),
		.box_bottom(box_bottom)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clamp16(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	// Box of the scaled frame rotated by -angle about the position.
	function automatic box_t predict_box(sprite_t sp);
		longint px, py, sx, sy, a, sw, sh, num, idx, s, c, rx, ry, ix, iy;
		longint minx, maxx, miny, maxy;
		longint dx [2];
		longint dy [2];
		longint unsigned k, q, r, x, x2, ts, tc, t, s0, c0;
		int i, j;
		box_t b;
		px = longint'(sp.px);
		py = longint'(sp.py);
		sx = longint'(sp.sx);
		sy = longint'(sp.sy);
		a = longint'(sp.ang);
		sw = longint'(frame_w_q) * (sx < 0 ? -sx : sx);
		sh = longint'(frame_h_q) * (sy < 0 ? -sy : sy);
		dx[0] = -sw * longint'(origin_x_q);
		dx[1] = sw * (256 - longint'(origin_x_q));
		dy[0] = -sh * longint'(origin_y_q);
		dy[1] = sh * (256 - longint'(origin_y_q));

		// phase step, rounded half up, then wrapped to one turn
		num = 2 * (-a * (longint'(1) << TBITS)) + TURN;
		if (num >= 0)
			idx = num / (2 * TURN);
		else
			idx = -((-num + 2 * TURN - 1) / (2 * TURN));
		k = longint'(idx) & ((longint'(1) << TBITS) - 1);
		q = (k >> (TBITS - 2)) & 3;
		r = k & ((longint'(1) << (TBITS - 2)) - 1);

		x = (r * PI_FIX + (64'd1 << (TBITS + 8))) >> (TBITS + 9);
		x2 = (x * x) >> 30;
		ts = UNIT_Q30;
		tc = UNIT_Q30;
		for (i = 0; i < 8; i++) begin
			t = ((x2 * ts) >> 30) / SIN_DIV[i];
			ts = (t >= UNIT_Q30) ? 64'd0 : UNIT_Q30 - t;
			t = ((x2 * tc) >> 30) / COS_DIV[i];
			tc = (t >= UNIT_Q30) ? 64'd0 : UNIT_Q30 - t;
		end
		s0 = (((x * ts) >> 30) + (64'd1 << 15)) >> 16;
		c0 = (tc + (64'd1 << 15)) >> 16;
		case (q)
			0: begin
				s = longint'(s0);
				c = longint'(c0);
			end
			1: begin
				s = longint'(c0);
				c = -longint'(s0);
			end
			2: begin
				s = -longint'(s0);
				c = -longint'(c0);
			end
			default: begin
				s = -longint'(c0);
				c = longint'(s0);
			end
		endcase

		minx = 0;
		maxx = 0;
		miny = 0;
		maxy = 0;
		for (i = 0; i < 2; i++) begin
			for (j = 0; j < 2; j++) begin
				rx = px * (longint'(1) << 22) + dx[i] * c - dy[j] * s;
				ry = py * (longint'(1) << 22) + dx[i] * s + dy[j] * c;
				// truncate toward zero
				ix = (rx < 0) ? -((-rx) >>> 30) : (rx >>> 30);
				iy = (ry < 0) ? -((-ry) >>> 30) : (ry >>> 30);
				if ((i == 0 && j == 0) || ix < minx)
					minx = ix;
				if ((i == 0 && j == 0) || ix > maxx)
					maxx = ix;
				if ((i == 0 && j == 0) || iy < miny)
					miny = iy;
				if ((i == 0 && j == 0) || iy > maxy)
					maxy = iy;
			end
		end
		b.left = BOX_W'(clamp16(minx));
		b.top = BOX_W'(clamp16(maxy));
		b.right = BOX_W'(clamp16(maxx));
		b.bottom = BOX_W'(clamp16(miny));
		return b;
	endfunction

	function automatic int draw_wait(bit burst);
		return burst ? 0 : int'($urandom_range(0, 12));
	endfunction

	// driver
	sprite_t cur;
	int send_idle = 0;
	bit send_burst = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				boxes_due.push_back(predict_box(cur));
				if ($urandom_range(0, 39) == 0)
					send_burst = !send_burst;
				send_idle = draw_wait(send_burst);
			end
			if (!in_valid || in_ready) begin
				if (send_idle > 0) begin
					send_idle--;
					in_valid <= 1'b0;
				end else if (sprites_pending.size() > 0) begin
					cur = sprites_pending.pop_front();
					pos_x <= cur.px;
					pos_y <= cur.py;
					scale_x <= cur.sx;
					scale_y <= cur.sy;
					angle <= cur.ang;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	box_t want;
	int recv_stall = 0;
	bit recv_burst = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (out_valid && out_ready) begin
			if (boxes_due.size() == 0) begin
				$error("box transfer with no expected box pending");
				mismatches++;
			end else begin
				want = boxes_due.pop_front();
				boxes_checked++;
				if (box_left !== want.left) begin
					$error("box_left: expected %0d, got %0d", want.left, box_left);
					mismatches++;
				end
				if (box_top !== want.top) begin
					$error("box_top: expected %0d, got %0d", want.top, box_top);
					mismatches++;
				end
				if (box_right !== want.right) begin
					$error("box_right: expected %0d, got %0d", want.right, box_right);
					mismatches++;
				end
				if (box_bottom !== want.bottom) begin
					$error("box_bottom: expected %0d, got %0d", want.bottom, box_bottom);
					mismatches++;
				end
			end
			if ($urandom_range(0, 39) == 0)
				recv_burst = !recv_burst;
			recv_stall = draw_wait(recv_burst);
			out_ready <= (recv_stall == 0);
		end else if (recv_stall > 0) begin
			recv_stall--;
			out_ready <= (recv_stall == 0);
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic add_sprite(int px, int py, int sx, int sy, int a);
		sprite_t sp;
		sp.px = px[POS_W-1:0];
		sp.py = py[POS_W-1:0];
		sp.sx = sx[SCALE_W-1:0];
		sp.sy = sy[SCALE_W-1:0];
		sp.ang = a[ANGLE_W-1:0];
		sprites_pending.push_back(sp);
		boxes_owed++;
	endtask

	task automatic set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_FRAME_WIDTH: frame_w_q = data;
			CFG_FRAME_HEIGHT: frame_h_q = data;
			CFG_ORIGIN_X: origin_x_q = data[ORIGIN_W-1:0];
			CFG_ORIGIN_Y: origin_y_q = data[ORIGIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	// hold until every queued sprite has come back as a box
	task automatic drain();
		while (boxes_checked != boxes_owed)
			@(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] rand_dim();
		case ($urandom_range(0, 5))
			0: return CFG_DATA_W'($urandom);
			1: return $urandom_range(0, 1) ? 12'd4095 : 12'd0;
			default: return CFG_DATA_W'($urandom_range(1, 200));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] rand_pivot();
		case ($urandom_range(0, 5))
			0: return CFG_DATA_W'($urandom);
			1: begin
				case ($urandom_range(0, 2))
					0: return 12'd0;
					1: return 12'd256;
					default: return 12'd511;
				endcase
			end
			default: return CFG_DATA_W'($urandom_range(0, 256));
		endcase
	endfunction

	initial begin
		int px, py, sx, sy, a;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// reset configuration: 32x32 frame, centered pivot
		add_sprite(0, 0, 256, 256, 0);
		add_sprite(8388607, 8388607, 4095, 4095, 0);
		add_sprite(-8388608, -8388608, -4096, -4096, 0);
		add_sprite(2560, -2560, 256, 512, 23040);
		add_sprite(2560, -2560, 256, 512, -23040);
		add_sprite(-1000, 3000, 300, 200, 32767);
		add_sprite(-1000, 3000, 300, 200, -32768);
		add_sprite(0, 0, 256, 512, 5760);
		add_sprite(0, 0, 256, 512, 11520);
		add_sprite(0, 0, 256, 512, -5760);
		add_sprite(0, 0, 256, 256, 2880);
		add_sprite(1234, 5678, 0, 256, 1000);
		add_sprite(1234, 5678, 256, 0, -1000);
		add_sprite(8388607, -8388608, -4096, 4095, 2880);
		add_sprite(-129, 129, -1, 1, 45);
		add_sprite(77, -77, -256, -512, -45);
		add_sprite(-8388608, 8388607, 4095, -4096, -2880);
		add_sprite(-300, -300, 0, 0, 17280);
		drain();

		// extremes: empty width, full height, pivot at the low and high corners
		set_reg(CFG_FRAME_WIDTH, 12'd0);
		set_reg(CFG_FRAME_HEIGHT, 12'd4095);
		set_reg(CFG_ORIGIN_X, 12'd0);
		set_reg(CFG_ORIGIN_Y, 12'd256);
		set_reg(4'd15, 12'hFFF);
		end_writes();
		add_sprite(0, 0, 256, 256, 0);
		add_sprite(5000, -5000, 4095, 1, 2880);
		add_sprite(-5000, 5000, 1, -4096, -11520);
		drain();

		// full width, empty height, pivot outside the frame
		set_reg(CFG_FRAME_WIDTH, 12'd4095);
		set_reg(CFG_FRAME_HEIGHT, 12'd0);
		set_reg(CFG_ORIGIN_X, 12'd511);
		set_reg(CFG_ORIGIN_Y, 12'd0);
		end_writes();
		add_sprite(0, 0, 1, 256, 0);
		add_sprite(256, 256, 16, 256, 5760);
		add_sprite(-256, 0, -4096, 256, 1440);
		drain();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			set_reg(CFG_FRAME_WIDTH, rand_dim());
			set_reg(CFG_FRAME_HEIGHT, rand_dim());
			set_reg(CFG_ORIGIN_X, rand_pivot());
			set_reg(CFG_ORIGIN_Y, rand_pivot());
			set_reg(CFG_INDEX_W'($urandom_range(4, 15)), CFG_DATA_W'($urandom));
			end_writes();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 3) == 0) begin
					px = int'($urandom);
					py = int'($urandom);
				end else begin
					px = int'($urandom_range(0, 2097152)) - 1048576;
					py = int'($urandom_range(0, 2097152)) - 1048576;
				end
				if ($urandom_range(0, 3) == 0) begin
					sx = int'($urandom);
					sy = int'($urandom);
				end else begin
					sx = int'($urandom_range(0, 1024)) - 512;
					sy = int'($urandom_range(0, 1024)) - 512;
				end
				case ($urandom_range(0, 7))
					0: a = int'($urandom);
					1: a = 5760 * (int'($urandom_range(0, 8)) - 4);
					default: a = int'($urandom_range(0, 46080)) - 23040;
				endcase
				add_sprite(px, py, sx, sy, a);
			end
			drain();
		end

		repeat (PIPE_DEPTH * 4) @(posedge clk);
		if (mismatches == 0 && boxes_due.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/rsbb_pkg.sv
rtl/rsbb_trig_rom.sv
rtl/rsbb_phase.sv
rtl/rsbb_reduce.sv
rtl/rotated_sprite_bounding_box.sv
tb/tb_rotated_sprite_bounding_box.sv
